/* design/lspm_pkg.sv */
// Shared constants and types for the longest matching-sum run block.
package lspm_pkg;

    localparam int VAL_W      = 16;
    localparam int SUM_W      = 24;
    localparam int NEED_W     = SUM_W + 1;
    localparam int LEN_OUT_W  = 9;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int MAX_LEN_DEF = 256;

    // control flags of a query moving down the chain
    typedef struct packed {
        logic valid;
        logic last;
        logic too_long;
        logic found;
    } qctl_t;

endpackage

/* design/longest_subarray_sum_prefix_match_top.sv */
// Top level: prefix-sum front end, chain of compare cells and result register.
//
// Input stream (s_axis_*): one signed 16-bit element per item, tlast marks the
// final element of a sequence. Output stream (m_axis_*): one item per sequence,
// the longest run length summing to target_sum (0 if none) and a capacity flag.
// target_sum is written through cfg_wr_en / cfg_wr_data while the block idles;
// the user must keep to this, the block does not enforce it. Each element
// enters the chain of MAX_LEN cells; its query moves one cell per cycle while
// the chain advances, one cell per stored prefix sum, and the earliest equal
// sum sets its length. A result passes the front-end register, the chain cells
// and the output register. Elements beyond MAX_LEN in a sequence are dropped
// and too_long is raised. Reset clears the sum, count, flags and chain; stored
// sums are left as they are. One element is taken per cycle, but while a
// result waits on m_axis_tready the whole chain holds and s_axis_tready is low;
// the result register stays valid and stable.
module longest_subarray_sum_prefix_match_top #(
    parameter int MAX_LEN = lspm_pkg::MAX_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lspm_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [15:0] value
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lspm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // [8:0] longest_len, zero fill
    output logic                                m_axis_tuser,  // [0] too_long
    input  logic                                cfg_wr_en,
    input  logic [lspm_pkg::SUM_W-1:0]          cfg_wr_data    // target_sum
);
    import lspm_pkg::*;

    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int XW = LW + LEN_OUT_W + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_LEN);
    localparam logic [XW-1:0] LEN_SAT    = XW'((1 << LEN_OUT_W) - 1);

    logic [SUM_W-1:0]  target_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CW-1:0]     count_reg;
    logic              cap_reg;
    logic              advance;
    logic              accept;
    logic              room;
    logic [NEED_W-1:0] need_next;

    qctl_t             ctl_chain  [0:MAX_LEN];
    logic [NEED_W-1:0] need_chain [0:MAX_LEN];
    logic [IW-1:0]     idx_chain  [0:MAX_LEN];
    logic [LW-1:0]     len_chain  [0:MAX_LEN];

    qctl_t             fctl_reg;
    qctl_t             fctl_next;
    logic [NEED_W-1:0] fneed_reg;
    logic [IW-1:0]     fidx_reg;
    logic [LW-1:0]     flen_reg;
    logic [LW-1:0]     flen_next;

    logic [LW-1:0]     best_reg;
    logic [LW-1:0]     best_next;
    logic [LW-1:0]     cand;
    logic              out_valid_reg;
    logic [LEN_OUT_W-1:0] out_len_reg;
    logic              out_flag_reg;
    logic [XW-1:0]     best_ext;
    qctl_t             tail;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign room          = (count_reg < FULL_COUNT);

    // front end: running sum, required earlier sum, equality with target
    assign sum_next  = sum_reg + {{(SUM_W-VAL_W){s_axis_tdata[VAL_W-1]}},
                                  s_axis_tdata[VAL_W-1:0]};
    assign need_next = {sum_next[SUM_W-1], sum_next}
                       - {target_reg[SUM_W-1], target_reg};

    always_comb
    begin
        fctl_next          = '0;
        fctl_next.valid    = accept;
        fctl_next.last     = s_axis_tlast;
        fctl_next.too_long = cap_reg || !room;
        flen_next          = '0;
        if (!room)
        begin
            fctl_next.found = 1'b1;   // dropped item: no match, length 0
        end
        else if (sum_next == target_reg)
        begin
            fctl_next.found = 1'b1;
            flen_next       = LW'(count_reg) + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            target_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            cap_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                cap_reg   <= 1'b0;
            end
            else if (room)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_reg + CW'(1);
            end
            else
            begin
                cap_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fctl_reg <= '0;
        end
        else if (advance)
        begin
            fctl_reg <= fctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fneed_reg <= need_next;
            fidx_reg  <= count_reg[IW-1:0];
            flen_reg  <= flen_next;
        end
    end

    assign ctl_chain[0]  = fctl_reg;
    assign need_chain[0] = fneed_reg;
    assign idx_chain[0]  = fidx_reg;
    assign len_chain[0]  = flen_reg;

    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_cell
        lspm_cell #(
            .MAX_LEN  (MAX_LEN),
            .CELL_IDX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .wr_en    (accept && room && (count_reg == CW'(k))),
            .wr_sum   (sum_next),
            .ctl_in   (ctl_chain[k]),
            .need_in  (need_chain[k]),
            .idx_in   (idx_chain[k]),
            .len_in   (len_chain[k]),
            .ctl_out  (ctl_chain[k+1]),
            .need_out (need_chain[k+1]),
            .idx_out  (idx_chain[k+1]),
            .len_out  (len_chain[k+1])
        );
    end

    // tail: fold the finished queries of a sequence into the best length
    assign tail      = ctl_chain[MAX_LEN];
    assign cand      = tail.found ? len_chain[MAX_LEN] : '0;
    assign best_next = (cand > best_reg) ? cand : best_reg;
    assign best_ext  = XW'(best_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance && tail.valid)
            begin
                best_reg <= tail.last ? '0 : best_next;
            end
            if (advance)
            begin
                out_valid_reg <= tail.valid && tail.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail.valid && tail.last)
        begin
            out_len_reg  <= (best_ext > LEN_SAT) ? LEN_SAT[LEN_OUT_W-1:0]
                                                 : best_ext[LEN_OUT_W-1:0];
            out_flag_reg <= tail.too_long;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W-LEN_OUT_W){1'b0}}, out_len_reg};
    assign m_axis_tuser  = out_flag_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("element count beyond capacity");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> count_reg == '0 && sum_reg == '0 && !cap_reg)
        else $error("sequence state not cleared after last item");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(tail.valid && tail.last))
        else $error("result raised without a finished last query");

    a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(fctl_reg) && $stable(best_reg))
        else $error("chain moved while the output was stalled");

endmodule

/* design/lspm_cell.sv */
// One chain cell: holds a stored prefix sum and checks the passing query against it.
module lspm_cell #(
    parameter int MAX_LEN  = lspm_pkg::MAX_LEN_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            wr_en,
    input  logic [lspm_pkg::SUM_W-1:0]      wr_sum,
    input  lspm_pkg::qctl_t                 ctl_in,
    input  logic [lspm_pkg::NEED_W-1:0]     need_in,
    input  logic [$clog2(MAX_LEN)-1:0]      idx_in,
    input  logic [$clog2(MAX_LEN+1)-1:0]    len_in,
    output lspm_pkg::qctl_t                 ctl_out,
    output logic [lspm_pkg::NEED_W-1:0]     need_out,
    output logic [$clog2(MAX_LEN)-1:0]      idx_out,
    output logic [$clog2(MAX_LEN+1)-1:0]    len_out
);
    import lspm_pkg::*;

    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [SUM_W-1:0]  sum_reg;
    qctl_t             ctl_reg;
    qctl_t             ctl_next;
    logic [NEED_W-1:0] need_reg;
    logic [IW-1:0]     idx_reg;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     len_next;
    logic              hit;

    // earliest stored sum wins, so a query already matched passes through
    assign hit = ctl_in.valid && !ctl_in.found && (MY_IDX < idx_in)
                 && ({sum_reg[SUM_W-1], sum_reg} == need_in);

    always_comb
    begin
        ctl_next = ctl_in;
        len_next = len_in;
        if (hit)
        begin
            ctl_next.found = 1'b1;
            len_next       = LW'(idx_in) - LW'(MY_IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sum_reg <= wr_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            need_reg <= need_in;
            idx_reg  <= idx_in;
            len_reg  <= len_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign need_out = need_reg;
    assign idx_out  = idx_reg;
    assign len_out  = len_reg;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the longest matching-sum run block.
`timescale 1ns / 100ps

module tb_top;
    import lspm_pkg::*;

    localparam int RUN_CAP = MAX_LEN_DEF;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 55;

    typedef struct packed {
        logic [LEN_OUT_W-1:0] len;
        logic                 too_long;
    } run_result_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    typed;
        run_result_t             res;
    } dir_row_t;

    typedef enum int {FILL_MIX, FILL_ZERO, FILL_MIN, FILL_WIDE} fill_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_IN_W-1:0]   s_axis_tdata = '0;    // [15:0] value
    logic                    s_axis_tlast = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_axis_tdata;         // [8:0] longest_len, zero fill
    logic                    m_axis_tuser;         // [0] too_long
    logic                    cfg_wr_en = 1'b0;
    logic [SUM_W-1:0]        cfg_wr_data = '0;     // target_sum
    logic                    calm = 1'b0;

    // predictor state
    logic signed [SUM_W-1:0] target_reg;
    logic signed [SUM_W-1:0] acc_sum;
    int                      elem_cnt;
    int                      best_run;
    logic                    overflow_seen;
    logic signed [SUM_W-1:0] seen_sums [RUN_CAP];

    run_result_t             pending_results [$];
    int                      mismatch_count = 0;
    int                      items_sent = 0;
    dir_row_t                dir_rows [22];

    longest_subarray_sum_prefix_match_top #(
        .MAX_LEN (RUN_CAP)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && (calm || ($urandom_range(0, 99) >= 15));
    end

    always @(posedge clk)
    begin
        run_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: longest_len=%0d too_long=%0b",
                       m_axis_tdata[LEN_OUT_W-1:0], m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[LEN_OUT_W-1:0] !== want.len)
                begin
                    $error("longest_len: expected %0d, got %0d", want.len,
                           m_axis_tdata[LEN_OUT_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.too_long)
                begin
                    $error("too_long: expected %0b, got %0b", want.too_long, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // longest run ending at each element; one result per sequence
    task automatic track_longest_run(input logic signed [VAL_W-1:0] v, input logic is_last,
                                     input logic typed, input run_result_t typed_res);
        longint      need_sum;
        logic        hit;
        run_result_t res;
        if (elem_cnt < RUN_CAP)
        begin
            acc_sum = acc_sum + v;
            if (acc_sum == target_reg && elem_cnt + 1 > best_run)
                best_run = elem_cnt + 1;
            need_sum = longint'(acc_sum) - longint'(target_reg);
            hit = 1'b0;
            for (int j = 0; j < elem_cnt; j++)
            begin
                if (!hit && longint'(seen_sums[j]) == need_sum)
                begin
                    hit = 1'b1;
                    if (elem_cnt - j > best_run)
                        best_run = elem_cnt - j;
                end
            end
            seen_sums[elem_cnt] = acc_sum;
            elem_cnt++;
        end
        else
            overflow_seen = 1'b1;
        if (is_last)
        begin
            res.len = (best_run > 511) ? 9'd511 : LEN_OUT_W'(best_run);
            res.too_long = overflow_seen;
            pending_results.push_back(typed ? typed_res : res);
            acc_sum = '0;
            elem_cnt = 0;
            best_run = 0;
            overflow_seen = 1'b0;
        end
    endtask

    task automatic send_element(input logic signed [VAL_W-1:0] v, input logic is_last,
                                input logic typed, input run_result_t typed_res);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tlast <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_longest_run(v, is_last, typed, typed_res);
        items_sent++;
    endtask

    task automatic send_run(input int run_len, input fill_t fill);
        logic signed [VAL_W-1:0] v;
        int                      pick;
        for (int k = 0; k < run_len; k++)
        begin
            case (fill)
                FILL_ZERO: v = '0;
                FILL_MIN:  v = 16'sh8000;
                FILL_WIDE: v = VAL_W'($urandom);
                default:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        v = VAL_W'(int'($urandom_range(0, 8)) - 4);
                    else if (pick < 8)
                        v = VAL_W'(int'($urandom_range(0, 200)) - 100);
                    else
                        v = VAL_W'($urandom);
                end
            endcase
            send_element(v, k == run_len - 1, 1'b0, '0);
        end
    endtask

    // holds the sender until every result is in, optionally letting the chain empty
    task automatic wait_results(input logic settle);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (RUN_CAP + 4) @(posedge clk);
    endtask

    task automatic write_target(input logic signed [SUM_W-1:0] t);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= t;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        target_reg = t;
    endtask

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic signed [SUM_W-1:0] phase_targets [NUM_PHASES];
        int                      phase_start;
        logic                    paused;
        int                      run_len;

        target_reg = '0;
        acc_sum = '0;
        elem_cnt = 0;
        best_run = 0;
        overflow_seen = 1'b0;
        paused = 1'b0;

        // value, last, typed, {longest_len, too_long}
        dir_rows = '{
            '{16'sh0000, 1'b1, 1'b1, '{9'd1, 1'b0}},
            '{16'sh7fff, 1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sh8000, 1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sh0001, 1'b1, 1'b1, '{9'd3, 1'b0}},
            '{16'sh0005, 1'b1, 1'b1, '{9'd0, 1'b0}},
            '{-16'sd1,   1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sh0001, 1'b1, 1'b1, '{9'd2, 1'b0}},
            '{16'sd3,    1'b0, 1'b0, '{9'd0, 1'b0}},
            '{-16'sd3,   1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sd7,    1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sd2,    1'b0, 1'b0, '{9'd0, 1'b0}},
            '{-16'sd2,   1'b1, 1'b0, '{9'd0, 1'b0}},
            '{16'sh8000, 1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sh8000, 1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sh8000, 1'b1, 1'b1, '{9'd0, 1'b0}},
            '{16'sh7fff, 1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sh7fff, 1'b0, 1'b0, '{9'd0, 1'b0}},
            '{-16'sd32767, 1'b0, 1'b0, '{9'd0, 1'b0}},
            '{-16'sd32767, 1'b1, 1'b0, '{9'd0, 1'b0}},
            '{16'sd4,    1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sd0,    1'b0, 1'b0, '{9'd0, 1'b0}},
            '{16'sd0,    1'b1, 1'b0, '{9'd0, 1'b0}}
        };

        phase_targets = '{24'sd1, -24'sd1, 24'sd6, 24'sd0, 24'sh800000, 24'sh7fffff,
                          24'sd0, 24'sd0};
        phase_targets[3] = SUM_W'(int'($urandom_range(0, 80)) - 40);
        phase_targets[6] = SUM_W'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the target is zero
        foreach (dir_rows[r])
            send_element(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed,
                         dir_rows[r].res);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_results(1'b1);
            write_target(phase_targets[p]);
            calm <= (p == 3);
            case (p)
                4: send_run(RUN_CAP, FILL_MIN);
                5: send_run(RUN_CAP + 2, FILL_WIDE);
                6: send_run($urandom_range(RUN_CAP + 1, RUN_CAP + 8), FILL_MIX);
                7:
                begin
                    send_run(RUN_CAP, FILL_ZERO);
                    send_run(RUN_CAP + 4, FILL_ZERO);
                end
                default: ;
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if (p == 1 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2)
                begin
                    wait_results(1'b0);
                    paused = 1'b1;
                end
                run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                     : $urandom_range(13, 60);
                send_run(run_len, FILL_MIX);
            end
        end

        wait_results(1'b1);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* longest_subarray_sum_prefix_match_top.f */
design/lspm_pkg.sv
design/lspm_cell.sv
design/longest_subarray_sum_prefix_match_top.sv
test/tb_top.sv
